// ===== rtl/pmss_pkg.sv =====
// ----------------------------------------------------------------------------
// pmss_pkg
// Shared constants, types and helpers for the pointer motion scaler.
// ----------------------------------------------------------------------------
package pmss_pkg;

  localparam int DELTA_BITS_DEF = 12;
  localparam int RAW_BITS       = 12;
  localparam int LAYER_BITS     = 8;
  localparam int DIV_BITS       = 14;
  localparam int OUT_BITS       = 13;
  localparam int ACT_BITS       = 2;
  localparam int REPORT_LIMIT   = 2048;

  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 14;

  localparam logic [7:0] STOP_STATUS = 8'h04;

  // result action codes
  localparam logic [ACT_BITS-1:0] ACT_STOP  = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_NONE  = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_MOVE  = 2'd2;
  localparam logic [ACT_BITS-1:0] ACT_WHEEL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_ID  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SNIPE_ID   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_DIV = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SNIPE_DIV  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_X     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_Y     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_WHEEL = 3'd6;

  localparam logic [LAYER_BITS-1:0] SCROLL_ID_RST  = 8'd1;
  localparam logic [LAYER_BITS-1:0] SNIPE_ID_RST   = 8'd2;
  localparam logic [DIV_BITS-1:0]   SCROLL_DIV_RST = 14'd32;
  localparam logic [DIV_BITS-1:0]   SNIPE_DIV_RST  = 14'd4;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_start;
    logic mul;
    logic upd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic direct;
    logic last_axis;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [OUT_BITS-1:0] clamp_report(input logic signed [31:0] v);
    logic signed [OUT_BITS-1:0] r;
    if (v > REPORT_LIMIT) begin
      r = OUT_BITS'(REPORT_LIMIT);
    end else if (v < -REPORT_LIMIT) begin
      r = OUT_BITS'(-REPORT_LIMIT);
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pmss_div.sv =====
// ----------------------------------------------------------------------------
// pmss_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmss_div #(
  parameter int N = 16,
  parameter int D = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quot_o
);

  localparam int CNT_BITS = $clog2(N);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [N-1:0]        dvd_q, dvd_d;
  logic [D-1:0]        rem_q, rem_d;
  logic [D-1:0]        dsr_q, dsr_d;
  logic [D:0]          shifted;
  logic [D:0]          diff;
  logic                ge;

  assign shifted = {rem_q, dvd_q[N-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      dvd_d = {dvd_q[N-2:0], ge};
      rem_d = ge ? diff[D-1:0] : shifted[D-1:0];
      cnt_d = cnt_q + CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== rtl/pmss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmss_ctrl
// Sequencer: capture, layer update, per-axis divide, output register.
// ----------------------------------------------------------------------------
module pmss_ctrl
  import pmss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.direct ? S_FIN : S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = status_i.last_axis ? S_FIN : S_DSTART;
      end
      S_FIN: begin
        // previous result may still sit in the output register
        if (!out_valid_q || m_axis_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule

// ===== rtl/pmss_datapath.sv =====
// ----------------------------------------------------------------------------
// pmss_datapath
// Config registers, layer state, accumulators, shared divider, result regs.
// ----------------------------------------------------------------------------
module pmss_datapath
  import pmss_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o
);

  localparam int ACC_BITS  = ((DELTA_BITS > DIV_BITS) ? DELTA_BITS : DIV_BITS) + 2;
  localparam int QC_BITS   = OUT_BITS - 1;
  localparam int PROD_BITS = QC_BITS + DIV_BITS;
  localparam int PAD_BITS  = OUT_TDATA_BITS - ACT_BITS - 3 * OUT_BITS;

  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_SCROLL,
    MODE_SNIPE
  } mode_e;

  // configuration
  logic [LAYER_BITS-1:0] scroll_id_q, snipe_id_q;
  logic [DIV_BITS-1:0]   scroll_div_q, snipe_div_q;
  logic                  flip_x_q, flip_y_q, flip_w_q;

  // captured poll
  logic [7:0] status_q, xlo_q, ylo_q, hi_q;
  logic [LAYER_BITS-1:0] layer_q;

  // persistent state
  logic [LAYER_BITS-1:0]      prev_layer_q;
  logic signed [ACC_BITS-1:0] scroll_acc_q, snx_acc_q, sny_acc_q;

  // per-item work registers
  mode_e                      mode_q;
  logic                       axis_q;
  logic                       over_q, neg_q;
  logic [DIV_BITS-1:0]        dv_q;
  logic [QC_BITS-1:0]         qc_q;
  logic [PROD_BITS-1:0]       prod_q;
  logic [ACT_BITS-1:0]        res_act_q, out_act_q;
  logic signed [OUT_BITS-1:0] res_x_q, res_y_q, res_w_q;
  logic signed [OUT_BITS-1:0] out_x_q, out_y_q, out_w_q;

  logic [RAW_BITS-1:0]        raw_x, raw_y;
  logic [DELTA_BITS-1:0]      dx, dy;
  logic signed [ACC_BITS-1:0] dx_ext, dy_ext;
  logic signed [OUT_BITS-1:0] cx, cy;
  logic                       is_stop, scroll_hit, snipe_hit, clear_snipe, clear_scroll;
  mode_e                      mode;

  logic signed [ACC_BITS-1:0] sel_acc, acc_upd, prod_acc;
  logic [DIV_BITS-1:0]        sel_div, d_eff;
  logic [ACC_BITS-1:0]        mag, quot;
  logic [QC_BITS-1:0]         qc;
  logic signed [OUT_BITS-1:0] qpos, qs, qv;
  logic                       div_done;

  // ---------------------------------------------------------------- decode
  assign raw_x  = {hi_q[7:4], xlo_q};
  assign raw_y  = {hi_q[3:0], ylo_q};
  assign dx     = DELTA_BITS'(raw_x);
  assign dy     = DELTA_BITS'(raw_y);
  assign dx_ext = ACC_BITS'($signed(dx));
  assign dy_ext = ACC_BITS'($signed(dy));
  assign cx     = clamp_report(32'(dx_ext));
  assign cy     = clamp_report(32'(dy_ext));

  assign is_stop      = status_q == STOP_STATUS;
  assign snipe_hit    = layer_q == snipe_id_q;
  assign scroll_hit   = layer_q == scroll_id_q;
  assign clear_snipe  = snipe_hit && (prev_layer_q != snipe_id_q);
  assign clear_scroll = !clear_snipe && scroll_hit && (prev_layer_q != scroll_id_q);

  always_comb begin
    if (scroll_hit) begin
      mode = MODE_SCROLL;
    end else if (snipe_hit) begin
      mode = MODE_SNIPE;
    end else begin
      mode = MODE_DIRECT;
    end
  end

  // ------------------------------------------------------- divide operands
  always_comb begin
    if (mode_q == MODE_SCROLL) begin
      sel_acc = scroll_acc_q;
      sel_div = scroll_div_q;
    end else begin
      sel_acc = axis_q ? sny_acc_q : snx_acc_q;
      sel_div = snipe_div_q;
    end
  end

  assign d_eff    = (sel_div == '0) ? DIV_BITS'(1) : sel_div;
  assign mag      = sel_acc[ACC_BITS-1] ? ACC_BITS'(-sel_acc) : ACC_BITS'(sel_acc);
  assign qc       = (quot > ACC_BITS'(REPORT_LIMIT)) ? QC_BITS'(REPORT_LIMIT) : quot[QC_BITS-1:0];
  assign qpos     = $signed({1'b0, qc_q});
  assign qs       = neg_q ? -qpos : qpos;
  assign qv       = over_q ? qs : '0;
  assign prod_acc = ACC_BITS'(prod_q);
  assign acc_upd  = neg_q ? sel_acc + prod_acc : sel_acc - prod_acc;

  pmss_div #(
    .N (ACC_BITS),
    .D (DIV_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (d_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // -------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_id_q  <= SCROLL_ID_RST;
      snipe_id_q   <= SNIPE_ID_RST;
      scroll_div_q <= SCROLL_DIV_RST;
      snipe_div_q  <= SNIPE_DIV_RST;
      flip_x_q     <= 1'b0;
      flip_y_q     <= 1'b0;
      flip_w_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCROLL_ID:  scroll_id_q  <= cfg_data_i[LAYER_BITS-1:0];
        CFG_SNIPE_ID:   snipe_id_q   <= cfg_data_i[LAYER_BITS-1:0];
        CFG_SCROLL_DIV: scroll_div_q <= cfg_data_i[DIV_BITS-1:0];
        CFG_SNIPE_DIV:  snipe_div_q  <= cfg_data_i[DIV_BITS-1:0];
        CFG_FLIP_X:     flip_x_q     <= cfg_data_i[0];
        CFG_FLIP_Y:     flip_y_q     <= cfg_data_i[0];
        CFG_FLIP_WHEEL: flip_w_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ layer and accs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_layer_q <= '0;
      scroll_acc_q <= '0;
      snx_acc_q    <= '0;
      sny_acc_q    <= '0;
    end else if (cmd_i.prep && !is_stop) begin
      prev_layer_q <= layer_q;
      // equal ids: snipe accs cleared on entry, then scroll behavior
      if (scroll_hit) begin
        scroll_acc_q <= (clear_scroll ? '0 : scroll_acc_q) + dy_ext;
        if (clear_snipe) begin
          snx_acc_q <= '0;
          sny_acc_q <= '0;
        end
      end else if (snipe_hit) begin
        snx_acc_q <= (clear_snipe ? '0 : snx_acc_q) + dx_ext;
        sny_acc_q <= (clear_snipe ? '0 : sny_acc_q) + dy_ext;
      end
    end else if (cmd_i.upd && over_q) begin
      if (mode_q == MODE_SCROLL) begin
        scroll_acc_q <= acc_upd;
      end else if (axis_q) begin
        sny_acc_q <= acc_upd;
      end else begin
        snx_acc_q <= acc_upd;
      end
    end
  end

  // ------------------------------------------------------- work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_q <= s_axis_tdata_i[7:0];
      xlo_q    <= s_axis_tdata_i[15:8];
      ylo_q    <= s_axis_tdata_i[23:16];
      hi_q     <= s_axis_tdata_i[31:24];
      layer_q  <= s_axis_tdata_i[39:32];
    end

    if (cmd_i.prep) begin
      mode_q  <= mode;
      axis_q  <= 1'b0;
      res_w_q <= '0;
      if (!is_stop && mode == MODE_DIRECT) begin
        res_x_q <= flip_x_q ? -cx : cx;
        res_y_q <= flip_y_q ? -cy : cy;
      end else begin
        res_x_q <= '0;
        res_y_q <= '0;
      end
      if (is_stop) begin
        res_act_q <= ACT_STOP;
      end else if (mode == MODE_SCROLL) begin
        res_act_q <= ACT_NONE;
      end else begin
        res_act_q <= ACT_MOVE;
      end
    end

    if (cmd_i.div_start) begin
      over_q <= mag > ACC_BITS'(d_eff);
      neg_q  <= sel_acc[ACC_BITS-1];
      dv_q   <= d_eff;
    end

    if (cmd_i.mul) begin
      qc_q   <= qc;
      prod_q <= qc * dv_q;
    end

    if (cmd_i.upd) begin
      axis_q <= 1'b1;
      if (mode_q == MODE_SCROLL) begin
        res_act_q <= over_q ? ACT_WHEEL : ACT_NONE;
        res_w_q   <= flip_w_q ? -qv : qv;
      end else if (axis_q) begin
        res_y_q <= flip_y_q ? -qv : qv;
      end else begin
        res_x_q <= flip_x_q ? -qv : qv;
      end
    end

    if (cmd_i.load_out) begin
      out_act_q <= res_act_q;
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
      out_w_q   <= res_w_q;
    end
  end

  assign m_axis_tdata_o = {{PAD_BITS{1'b0}}, out_w_q, out_y_q, out_x_q, out_act_q};

  assign status_o.direct    = is_stop || (mode == MODE_DIRECT);
  assign status_o.last_axis = (mode_q != MODE_SNIPE) || axis_q;
  assign status_o.div_done  = div_done;

endmodule

// ===== rtl/pointer_motion_scroll_snipe_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// pointer_motion_scroll_snipe_scaler_unit
// Turns sensor polls into pointer moves or wheel steps by active layer.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      one sensor poll per transaction
// m_axis    out  m_axis_tvalid/tready      one report per poll
// cfg       in   cfg_we_i (no wait)        register index and write data
//
// Stop polls and plain-layer polls go from capture through prep straight to
// the output register. Scroll polls take one divide and snipe polls one per
// axis in the shared divider, N = max(DELTA_BITS, 14) + 2 bits wide, which
// gives one quotient bit per cycle.
// One poll is worked on at a time; a new poll is taken while the last report
// still waits in the output register, which holds until m_axis_tready_i.
// Reset clears layer history and accumulators, and resets configuration.
// ----------------------------------------------------------------------------
module pointer_motion_scroll_snipe_scaler_unit
  import pmss_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // motion_status, x_low_byte, y_low_byte, xy_high_byte, active_layer
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // action, move_x, move_y, wheel_steps, zero pad
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pmss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  pmss_datapath #(
    .DELTA_BITS (DELTA_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

// ===== rtl/pmss_checker.sv =====
// ----------------------------------------------------------------------------
// pmss_checker
// Port-level checks on the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module pmss_checker
  import pmss_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o
);

  logic [ACT_BITS-1:0] act;
  assign act = m_axis_tdata_o[1:0];

  // stalled report holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("report changed while stalled");

  // one poll in flight
  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("poll accepted while busy");

  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (act == ACT_STOP || act == ACT_NONE) |-> m_axis_tdata_o[47:2] == '0)
    else $error("stop or idle report carries values");

  // a wheel report moves no pointer and is never zero steps
  a_wheel_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && act == ACT_WHEEL |->
      m_axis_tdata_o[27:2] == '0 && m_axis_tdata_o[40:28] != '0)
    else $error("wheel report malformed");

endmodule

bind pointer_motion_scroll_snipe_scaler_unit pmss_checker u_checker (.*);

// ===== test/pointer_motion_scroll_snipe_scaler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_motion_scroll_snipe_scaler_unit_test
// Self-checking bench for the pointer motion scaler. A short table of directed
// polls is followed by random poll runs under several register settings. Each
// report is compared field by field with the table's expected report or else
// with an in-bench predictor of the scroll and snipe accumulators.
// ----------------------------------------------------------------------------
module pointer_motion_scroll_snipe_scaler_unit_test;
  import pmss_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_HOLD   = 400;

  // same bit order as s_axis_tdata (status in the lowest byte)
  typedef struct packed {
    logic [7:0] active_layer;
    logic [7:0] xy_high;
    logic [7:0] y_low;
    logic [7:0] x_low;
    logic [7:0] status;
  } poll_t;

  // same bit order as m_axis_tdata (action in the lowest bits)
  typedef struct packed {
    logic [6:0]                pad;
    logic signed [OUT_BITS-1:0] wheel;
    logic signed [OUT_BITS-1:0] move_y;
    logic signed [OUT_BITS-1:0] move_x;
    logic [ACT_BITS-1:0]        action;
  } report_t;

  typedef struct {
    poll_t   poll;
    bit      typed;
    report_t want;
  } poll_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_idx;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  pointer_motion_scroll_snipe_scaler_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // register mirror
  logic [LAYER_BITS-1:0] scroll_id, snipe_id;
  logic [DIV_BITS-1:0]   scroll_div, snipe_div;
  logic                  mirror_x, mirror_y, mirror_wheel;

  // layer history and accumulators
  logic [LAYER_BITS-1:0] prior_layer;
  int                    scroll_acc, snipe_acc_x, snipe_acc_y;

  report_t   expected_reports[$];
  poll_row_t poll_table[$];
  int        mismatch_count;
  int        src_idle_pct, dst_idle_pct;
  bit        hold_request;
  int        stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic poll_t mk_poll(input int status, input int dx, input int dy,
                                    input int layer);
    poll_t p;
    logic [11:0] xv, yv;
    xv = 12'(dx);
    yv = 12'(dy);
    p.status       = 8'(status);
    p.x_low        = xv[7:0];
    p.y_low        = yv[7:0];
    p.xy_high      = {xv[11:8], yv[11:8]};
    p.active_layer = 8'(layer);
    return p;
  endfunction

  function automatic report_t mk_report(input logic [ACT_BITS-1:0] act, input int mx,
                                        input int my, input int wh);
    report_t r;
    r        = '0;
    r.action = act;
    r.move_x = OUT_BITS'(mx);
    r.move_y = OUT_BITS'(my);
    r.wheel  = OUT_BITS'(wh);
    return r;
  endfunction

  function automatic int saturate_2048(input int v);
    if (v > REPORT_LIMIT) return REPORT_LIMIT;
    if (v < -REPORT_LIMIT) return -REPORT_LIMIT;
    return v;
  endfunction

  // whole steps leave the accumulator only past the divisor, remainder stays
  function automatic int take_steps(inout int acc, input logic [DIV_BITS-1:0] div,
                                    output bit past);
    int d, q;
    d = (div == '0) ? 1 : int'(div);
    past = (acc > d) || (acc < -d);
    if (!past) return 0;
    q = saturate_2048(acc / d);
    acc = acc - q * d;
    return q;
  endfunction

  function automatic report_t predict_report(input poll_t p);
    report_t r;
    logic signed [11:0] xs, ys;
    int  dx, dy, q;
    bit  past;
    r = mk_report(ACT_STOP, 0, 0, 0);
    if (p.status == STOP_STATUS) return r;
    xs = {p.xy_high[7:4], p.x_low};
    ys = {p.xy_high[3:0], p.y_low};
    dx = xs;
    dy = ys;
    if (p.active_layer == snipe_id && prior_layer != snipe_id) begin
      snipe_acc_x = 0;
      snipe_acc_y = 0;
    end else if (p.active_layer == scroll_id && prior_layer != scroll_id) begin
      scroll_acc = 0;
    end
    prior_layer = p.active_layer;

    if (p.active_layer == scroll_id) begin
      scroll_acc = scroll_acc + dy;
      q = take_steps(scroll_acc, scroll_div, past);
      if (!past) return mk_report(ACT_NONE, 0, 0, 0);
      return mk_report(ACT_WHEEL, 0, 0, mirror_wheel ? -q : q);
    end

    if (p.active_layer == snipe_id) begin
      snipe_acc_x = snipe_acc_x + dx;
      snipe_acc_y = snipe_acc_y + dy;
      dx = take_steps(snipe_acc_x, snipe_div, past);
      dy = take_steps(snipe_acc_y, snipe_div, past);
    end
    dx = saturate_2048(dx);
    dy = saturate_2048(dy);
    return mk_report(ACT_MOVE, mirror_x ? -dx : dx, mirror_y ? -dy : dy, 0);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    case (idx)
      CFG_SCROLL_ID:  scroll_id    = LAYER_BITS'(value);
      CFG_SNIPE_ID:   snipe_id     = LAYER_BITS'(value);
      CFG_SCROLL_DIV: scroll_div   = DIV_BITS'(value);
      CFG_SNIPE_DIV:  snipe_div    = DIV_BITS'(value);
      CFG_FLIP_X:     mirror_x     = value[0];
      CFG_FLIP_Y:     mirror_y     = value[0];
      CFG_FLIP_WHEEL: mirror_wheel = value[0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input int sid, input int nid, input int sdiv,
                                  input int ndiv, input int fx, input int fy,
                                  input int fw);
    write_register(CFG_SCROLL_ID, sid);
    write_register(CFG_SNIPE_ID, nid);
    write_register(CFG_SCROLL_DIV, sdiv);
    write_register(CFG_SNIPE_DIV, ndiv);
    write_register(CFG_FLIP_X, fx);
    write_register(CFG_FLIP_Y, fy);
    write_register(CFG_FLIP_WHEEL, fw);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // offer one poll; returns right after the edge that took it
  task automatic send_poll(input poll_t p, input bit typed, input report_t want);
    report_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_report(p);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_delta(input int dir);
    case ($urandom_range(3))
      0:       return dir * int'($urandom_range(0, 40));
      1:       return int'($urandom_range(0, 4095));
      2:       return dir * int'($urandom_range(512, 2047));
      default: begin
        case ($urandom_range(3))
          0:       return 2047;
          1:       return -2048;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // runs of polls on one layer so the accumulators build up, with stops and
  // stray layers mixed in
  task automatic run_random_polls(input int count);
    int layer, run_left, dir, status;
    run_left = 0;
    layer    = 0;
    dir      = 1;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 12);
        dir      = $urandom_range(1) ? 1 : -1;
        case ($urandom_range(9))
          0, 1, 2, 3: layer = scroll_id;
          4, 5, 6, 7: layer = snipe_id;
          default:    layer = $urandom_range(0, 255);
        endcase
      end
      run_left--;
      status = ($urandom_range(11) == 0) ? int'(STOP_STATUS) : int'($urandom_range(0, 255));
      if ($urandom_range(15) == 0)
        send_poll(mk_poll(status, pick_delta(dir), pick_delta(dir),
                          $urandom_range(0, 255)), 1'b0, '0);
      else
        send_poll(mk_poll(status, pick_delta(dir), pick_delta(dir), layer), 1'b0, '0);
    end
  endtask

  // receiver: random backpressure plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // report checker and stall watchdog
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report %h", m_axis_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (got.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
        if (got.move_x !== want.move_x)
          report_mismatch($sformatf("move_x %0d, want %0d", got.move_x, want.move_x));
        if (got.move_y !== want.move_y)
          report_mismatch($sformatf("move_y %0d, want %0d", got.move_y, want.move_y));
        if (got.wheel !== want.wheel)
          report_mismatch($sformatf("wheel_steps %0d, want %0d", got.wheel, want.wheel));
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    stall_cycles   = 0;
    hold_request   = 1'b0;
    src_idle_pct   = 32;
    dst_idle_pct   = 67;
    scroll_id      = SCROLL_ID_RST;
    snipe_id       = SNIPE_ID_RST;
    scroll_div     = SCROLL_DIV_RST;
    snipe_div      = SNIPE_DIV_RST;
    mirror_x       = 1'b0;
    mirror_y       = 1'b0;
    mirror_wheel   = 1'b0;
    prior_layer    = '0;
    scroll_acc     = 0;
    snipe_acc_x    = 0;
    snipe_acc_y    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;

    // directed polls at reset settings: scroll layer 1, snipe layer 2, div 32 / 4
    poll_table.push_back('{mk_poll(STOP_STATUS, 12'h123, -5, 1), 1'b1,
                           mk_report(ACT_STOP, 0, 0, 0)});
    poll_table.push_back('{mk_poll(8'h80, 2047, -2048, 0), 1'b1,
                           mk_report(ACT_MOVE, 2047, -2048, 0)});
    poll_table.push_back('{mk_poll(8'h00, -2048, -1, 0), 1'b1,
                           mk_report(ACT_MOVE, -2048, -1, 0)});
    poll_table.push_back('{mk_poll(8'hff, 0, 0, 0), 1'b1, mk_report(ACT_MOVE, 0, 0, 0)});
    poll_table.push_back('{mk_poll(8'h05, -1, 1, 255), 1'b1,
                           mk_report(ACT_MOVE, -1, 1, 0)});
    // scroll entry, accumulator exactly at the divisor: nothing reported
    poll_table.push_back('{mk_poll(8'h80, 100, 32, 1), 1'b1,
                           mk_report(ACT_NONE, 0, 0, 0)});
    poll_table.push_back('{mk_poll(8'h80, 0, 1, 1), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, -2048, 2047, 1), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, 0, -2048, 1), 1'b0, '0});
    // stop leaves layer history alone
    poll_table.push_back('{mk_poll(STOP_STATUS, 7, 7, 2), 1'b1,
                           mk_report(ACT_STOP, 0, 0, 0)});
    // snipe entry, both axes within the divisor
    poll_table.push_back('{mk_poll(8'h80, 3, -4, 2), 1'b1, mk_report(ACT_MOVE, 0, 0, 0)});
    poll_table.push_back('{mk_poll(8'h80, 2, -1, 2), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, 2047, -2048, 2), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, -2048, 2047, 2), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, 50, 60, 0), 1'b1, mk_report(ACT_MOVE, 50, 60, 0)});
    poll_table.push_back('{mk_poll(8'h80, 0, 2047, 1), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h80, 7, 7, 2), 1'b0, '0});
    poll_table.push_back('{mk_poll(8'h84, 1, 2, 0), 1'b1, mk_report(ACT_MOVE, 1, 2, 0)});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (poll_table[i]) send_poll(poll_table[i].poll, poll_table[i].typed,
                                      poll_table[i].want);
    run_random_polls(110);

    wait_drained();
    program_settings(3, 7, 1, 1, 1, 0, 1);
    run_random_polls(110);

    wait_drained();
    src_idle_pct = 67;
    dst_idle_pct = 32;
    program_settings(0, 255, 16383, 16383, 0, 1, 0);
    run_random_polls(110);

    // equal ids and zero divisors
    wait_drained();
    program_settings(5, 5, 0, 0, 1, 1, 1);
    run_random_polls(110);

    wait_drained();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    program_settings(9, 4, 100, 13, 0, 0, 0);
    hold_request = 1'b1;
    run_random_polls(120);

    wait_drained();
    program_settings(255, 0, 2, 3, 1, 1, 0);
    run_random_polls(120);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pmss_pkg.sv
rtl/pmss_div.sv
rtl/pmss_ctrl.sv
rtl/pmss_datapath.sv
rtl/pointer_motion_scroll_snipe_scaler_unit.sv
rtl/pmss_checker.sv
test/pointer_motion_scroll_snipe_scaler_unit_test.sv
